// File: rtl/core/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants of the keyed slot table
// Slot geometry, key format, operation codes, queue entry and result layout.
// ----------------------------------------------------------------------------
package kst_pkg;

  // slot geometry
  localparam int unsigned SLOTS      = 1024;
  localparam int unsigned IDX_W      = $clog2(SLOTS);
  localparam int unsigned SIZE_W     = IDX_W + 1;
  localparam int unsigned LANES      = 4;
  localparam int unsigned LANE_W     = $clog2(LANES);
  localparam int unsigned ROWS       = SLOTS / LANES;
  localparam int unsigned ROW_W      = $clog2(ROWS);

  // keys: unsigned Q1.15, one extra bit for the empty sentinel 2.0
  localparam int unsigned KEY_IN_W   = 16;
  localparam int unsigned KEY_W      = KEY_IN_W + 1;
  localparam int unsigned ROW_DATA_W = KEY_W * LANES;
  localparam logic [KEY_W-1:0] KEY_EMPTY = {1'b1, {KEY_IN_W{1'b0}}};

  // register file
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned REG_IDX_W  = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TABLE_SIZE = '0;
  localparam logic [SIZE_W-1:0]    SIZE_RESET     = SIZE_W'(SLOTS);

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam int unsigned MODE_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_QUERY  = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_FIND   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_QUERY,
    OP_CLEAR,
    OP_FIND
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [IDX_W-1:0]    slot;
    logic [KEY_IN_W-1:0] key;
    logic                bad;
  } cmd_t;

  typedef struct packed {
    logic              is_member;
    logic [SIZE_W-1:0] min_index;
    logic [KEY_W-1:0]  min_key;
    logic              bad_index;
  } res_t;

  // table size as used: zero acts as one, above the slot count acts as full
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] n;
    n = raw;
    if (raw == '0) begin
      n = SIZE_W'(1);
    end else if (raw > SIZE_W'(SLOTS)) begin
      n = SIZE_W'(SLOTS);
    end
    return n;
  endfunction

endpackage

// File: rtl/core/kst_ram.sv
// ----------------------------------------------------------------------------
// kst_ram: generic single-port-write, single-port-read memory
// One write and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // storage write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/kst_front.sv
// ----------------------------------------------------------------------------
// kst_front: input side of the keyed slot table
// Takes input transfers, decodes the mode and checks the slot index against
// the table size, then hands a command to the queue.
// ----------------------------------------------------------------------------
module kst_front (
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [kst_pkg::MODE_W-1:0]   mode_i,
  input  logic [kst_pkg::IDX_W-1:0]    slot_index_i,
  input  logic [kst_pkg::KEY_IN_W-1:0] key_in_i,
  input  logic [kst_pkg::SIZE_W-1:0]   size_i,
  input  logic                         full_i,
  output logic                         push_o,
  output kst_pkg::cmd_t                cmd_o
);

  logic in_range;

  // stall only on a full queue
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  assign in_range = {1'b0, slot_index_i} < size_i;

  // mode decode and index check
  always_comb begin
    cmd_o.slot = slot_index_i;
    cmd_o.key  = key_in_i;
    cmd_o.bad  = 1'b0;
    cmd_o.op   = kst_pkg::OP_NONE;
    unique case (kst_pkg::mode_e'(mode_i))
      kst_pkg::MODE_INSERT: begin
        cmd_o.op  = in_range ? kst_pkg::OP_INSERT : kst_pkg::OP_NONE;
        cmd_o.bad = !in_range;
      end
      kst_pkg::MODE_REMOVE: begin
        cmd_o.op  = in_range ? kst_pkg::OP_REMOVE : kst_pkg::OP_NONE;
        cmd_o.bad = !in_range;
      end
      kst_pkg::MODE_QUERY: begin
        cmd_o.op  = in_range ? kst_pkg::OP_QUERY : kst_pkg::OP_NONE;
        cmd_o.bad = !in_range;
      end
      kst_pkg::MODE_CLEAR: cmd_o.op = kst_pkg::OP_CLEAR;
      kst_pkg::MODE_FIND:  cmd_o.op = kst_pkg::OP_FIND;
      default:             cmd_o.op = kst_pkg::OP_NONE;
    endcase
  end

endmodule

// File: rtl/core/kst_fifo.sv
// ----------------------------------------------------------------------------
// kst_fifo: short command queue between front and back
// Lets the input side keep taking transfers while the back is busy.
// ----------------------------------------------------------------------------
module kst_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  kst_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output kst_pkg::cmd_t cmd_o
);

  kst_pkg::cmd_t                  entry_q [kst_pkg::QUEUE_DEPTH];
  logic [kst_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [kst_pkg::QUEUE_PTR_W:0]   count_q;
  logic                            do_push, do_pop;

  assign full_o  = count_q == (kst_pkg::QUEUE_PTR_W + 1)'(kst_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + kst_pkg::QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + kst_pkg::QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (kst_pkg::QUEUE_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (kst_pkg::QUEUE_PTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: rtl/core/kst_back.sv
// ----------------------------------------------------------------------------
// kst_back: execution side of the keyed slot table
// Owns the row memory (four slots a row) and its row valid bits, does the
// read-modify-write of insert and remove, the scan of find-minimum, and holds
// the output register.
// ----------------------------------------------------------------------------
module kst_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [kst_pkg::SIZE_W-1:0] size_i,
  input  logic                       clear_i,
  input  logic                       cmd_valid_i,
  input  kst_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output kst_pkg::res_t              res_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RMW  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  kst_pkg::cmd_t                   cmd_q;
  logic [kst_pkg::ROWS-1:0]        row_valid_q, row_valid_d;
  kst_pkg::res_t                   res_q, res_d;
  kst_pkg::res_t                   out_q;
  logic                            out_valid_q;

  // scan pipeline
  logic [kst_pkg::ROW_W:0]         iss_q, iss_d;
  logic                            rd_v_q, rd_rv_q;
  logic [kst_pkg::ROW_W-1:0]       rd_row_q;
  logic                            red_v_q;
  logic [kst_pkg::KEY_W-1:0]       red_key_q;
  logic [kst_pkg::IDX_W-1:0]       red_idx_q;
  logic [kst_pkg::KEY_W-1:0]       min_key_q, min_key_d;
  logic [kst_pkg::IDX_W-1:0]       min_idx_q, min_idx_d;

  // memory ports
  logic                            ram_we, ram_re;
  logic [kst_pkg::ROW_W-1:0]       ram_waddr, ram_raddr;
  logic [kst_pkg::ROW_DATA_W-1:0]  ram_wdata, ram_rdata;

  logic [kst_pkg::SIZE_W-1:0]      size_m1;
  logic [kst_pkg::ROW_W:0]         rows_used;
  logic                            scan_issue;
  logic                            out_free;
  logic [kst_pkg::ROW_W-1:0]       cmd_row;
  logic [kst_pkg::LANE_W-1:0]      cmd_lane;
  logic                            row_live;
  logic [kst_pkg::KEY_W-1:0]       lane_key [kst_pkg::LANES];
  logic [kst_pkg::KEY_W-1:0]       new_key;
  logic [kst_pkg::KEY_W-1:0]       best_key;
  logic [kst_pkg::LANE_W-1:0]      best_lane;

  kst_ram #(
    .WIDTH (kst_pkg::ROW_DATA_W),
    .DEPTH (kst_pkg::ROWS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // rows covering the slots in use
  assign size_m1   = size_i - kst_pkg::SIZE_W'(1);
  assign rows_used = {1'b0, size_m1[kst_pkg::IDX_W-1:kst_pkg::LANE_W]}
                   + (kst_pkg::ROW_W + 1)'(1);

  assign scan_issue = (state_q == ST_SCAN) && (iss_q != rows_used);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cmd_pop_o  = (state_q == ST_IDLE) && cmd_valid_i;

  assign cmd_row  = cmd_q.slot[kst_pkg::IDX_W-1:kst_pkg::LANE_W];
  assign cmd_lane = cmd_q.slot[kst_pkg::LANE_W-1:0];
  assign new_key  = (cmd_q.op == kst_pkg::OP_INSERT) ? {1'b0, cmd_q.key} : kst_pkg::KEY_EMPTY;

  // unpack the read row; a row never written since the last clear reads empty
  assign row_live = (state_q == ST_RMW) ? row_valid_q[cmd_row] : rd_rv_q;

  always_comb begin
    for (int l = 0; l < kst_pkg::LANES; l++) begin
      lane_key[l] = row_live ? ram_rdata[l*kst_pkg::KEY_W +: kst_pkg::KEY_W]
                             : kst_pkg::KEY_EMPTY;
    end
  end

  // merged row for insert and remove
  always_comb begin
    for (int l = 0; l < kst_pkg::LANES; l++) begin
      ram_wdata[l*kst_pkg::KEY_W +: kst_pkg::KEY_W] =
        (kst_pkg::LANE_W'(l) == cmd_lane) ? new_key : lane_key[l];
    end
  end

  // smallest key within a row, lowest lane on ties
  always_comb begin
    best_key  = lane_key[0];
    best_lane = '0;
    for (int l = 1; l < kst_pkg::LANES; l++) begin
      if (lane_key[l] < best_key) begin
        best_key  = lane_key[l];
        best_lane = kst_pkg::LANE_W'(l);
      end
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    row_valid_d = row_valid_q;
    iss_d       = iss_q;
    min_key_d   = min_key_q;
    min_idx_d   = min_idx_q;
    ram_we      = 1'b0;
    ram_waddr   = cmd_row;
    ram_re      = 1'b0;
    ram_raddr   = iss_q[kst_pkg::ROW_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          res_d           = '0;
          res_d.bad_index = cmd_i.bad;
          case (cmd_i.op) inside
            kst_pkg::OP_INSERT, kst_pkg::OP_REMOVE, kst_pkg::OP_QUERY: begin
              ram_re    = 1'b1;
              ram_raddr = cmd_i.slot[kst_pkg::IDX_W-1:kst_pkg::LANE_W];
              state_d   = ST_RMW;
            end
            kst_pkg::OP_FIND: begin
              iss_d     = '0;
              min_key_d = kst_pkg::KEY_EMPTY;
              min_idx_d = '0;
              state_d   = ST_SCAN;
            end
            kst_pkg::OP_CLEAR: begin
              row_valid_d = '0;
              state_d     = ST_EMIT;
            end
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_RMW: begin
        if (cmd_q.op == kst_pkg::OP_QUERY) begin
          res_d.is_member = lane_key[cmd_lane] != kst_pkg::KEY_EMPTY;
        end else begin
          ram_we               = 1'b1;
          row_valid_d[cmd_row] = 1'b1;
        end
        state_d = ST_EMIT;
      end
      ST_SCAN: begin
        if (scan_issue) begin
          ram_re = 1'b1;
          iss_d  = iss_q + (kst_pkg::ROW_W + 1)'(1);
        end
        // fold the row winner into the running minimum
        if (red_v_q && (red_key_q < min_key_q)) begin
          min_key_d = red_key_q;
          min_idx_d = red_idx_q;
        end
        if (!scan_issue && !rd_v_q && !red_v_q) begin
          res_d.min_key   = min_key_q;
          res_d.min_index = {1'b0, min_idx_q};
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // a size write empties the table
    if (clear_i) begin
      row_valid_d = '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_valid_q <= '0;
      iss_q       <= '0;
      rd_v_q      <= 1'b0;
      red_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_valid_q <= row_valid_d;
      iss_q       <= iss_d;
      rd_v_q      <= scan_issue;
      red_v_q     <= rd_v_q;
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    res_q     <= res_d;
    min_key_q <= min_key_d;
    min_idx_q <= min_idx_d;
    if (scan_issue) begin
      rd_row_q <= iss_q[kst_pkg::ROW_W-1:0];
      rd_rv_q  <= row_valid_q[iss_q[kst_pkg::ROW_W-1:0]];
    end
    if (rd_v_q) begin
      red_key_q <= best_key;
      red_idx_q <= {rd_row_q, best_lane};
    end
    if ((state_q == ST_EMIT) && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// File: rtl/core/keyed_slot_table_with_argmin.sv
// ----------------------------------------------------------------------------
// keyed_slot_table_with_argmin: slot table with keyed insert and arg-min
// Table of 1024 slots with Q1.15 keys; insert, remove, query, clear and
// find-minimum, one result transfer for every input transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input and output channels move one transfer when valid is high and stall
//   is low. Every input transfer yields exactly one output transfer, in order.
//   The table_size register sits at byte address 0 of the APB port; writing
//   it empties the table. Write it only while no transfer is in flight.
// Steps (from the command reaching the back end to its result):
//   clear and ignored items      no row memory access
//   insert, remove, query        one row read; insert and remove write the row back
//   find minimum                 one row read per four slots of the n in use; the
//                                single read port of the row memory returns
//                                four slots per cycle
//   A two-entry command queue lets input transfers be taken while the back
//   end works and while a result waits in the output register.
// Reset empties the table at once (row valid bits) and sets the size to 1024.
// While the receiver stalls, the result holds, the back end waits once it has
// a second result ready, and input stalls when the queue is full.
// ----------------------------------------------------------------------------
module keyed_slot_table_with_argmin (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [kst_pkg::MODE_W-1:0]    mode_i,
  input  logic [kst_pkg::IDX_W-1:0]     slot_index_i,
  input  logic [kst_pkg::KEY_IN_W-1:0]  key_in_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          is_member_o,
  output logic [kst_pkg::SIZE_W-1:0]    min_index_o,
  output logic [kst_pkg::KEY_W-1:0]     min_key_o,
  output logic                          bad_index_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kst_pkg::PADDR_W-1:0]   paddr,
  input  logic [kst_pkg::PDATA_W-1:0]   pwdata,
  output logic [kst_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [kst_pkg::SIZE_W-1:0] table_size_q;
  logic [kst_pkg::SIZE_W-1:0] size_eff;
  logic                       reg_sel;
  logic                       cfg_we;

  logic                       q_push, q_full, q_valid, q_pop;
  kst_pkg::cmd_t              front_cmd, queue_cmd;
  kst_pkg::res_t              res;

  // register access
  assign pready  = 1'b1;
  assign reg_sel = paddr[kst_pkg::PADDR_W-1:2] == kst_pkg::REG_TABLE_SIZE;
  assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? kst_pkg::PDATA_W'(table_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= kst_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      table_size_q <= pwdata[kst_pkg::SIZE_W-1:0];
    end
  end

  assign size_eff = kst_pkg::eff_size(table_size_q);

  kst_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .slot_index_i (slot_index_i),
    .key_in_i     (key_in_i),
    .size_i       (size_eff),
    .full_i       (q_full),
    .push_o       (q_push),
    .cmd_o        (front_cmd)
  );

  kst_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (queue_cmd)
  );

  kst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_i      (size_eff),
    .clear_i     (cfg_we),
    .cmd_valid_i (q_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign is_member_o = res.is_member;
  assign min_index_o = res.min_index;
  assign min_key_o   = res.min_key;
  assign bad_index_o = res.bad_index;

  // an ignored item reports nothing but the flag
  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_index_o |-> !is_member_o && min_key_o == '0 && min_index_o == '0)
    else $error("bad index result carries data");

  // the reported index lies within the slots in use
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> min_index_o < size_eff)
    else $error("min index beyond table size");

  // an empty table answers with slot zero
  a_empty_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && min_key_o == kst_pkg::KEY_EMPTY |-> min_index_o == '0)
    else $error("empty minimum with nonzero index");

  // membership and a minimum never come in the same result
  a_member_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_member_o |-> min_key_o == '0 && !bad_index_o)
    else $error("query result mixed with find result");

endmodule

// File: tb/tb_keyed_slot_table_with_argmin.sv
// ----------------------------------------------------------------------------
// tb_keyed_slot_table_with_argmin: self-checking bench of the keyed slot table
// A directed table walks empty-table finds, ties, bad indices, the spare modes
// and table sizes at both ends. Random phases follow, one per table size and
// idle profile. A shadow copy of the table predicts every result transfer that the
// directed table does not type in.
module tb_keyed_slot_table_with_argmin;
  import kst_pkg::*;

  // spare mode codes, no operation behind them
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  // answers that can be written down directly
  localparam res_t ANS_NONE   = '0;
  localparam res_t ANS_EMPTY  = '{is_member: 1'b0, min_index: '0, min_key: KEY_EMPTY,
                                  bad_index: 1'b0};
  localparam res_t ANS_BAD    = '{is_member: 1'b0, min_index: '0, min_key: '0,
                                  bad_index: 1'b1};
  localparam res_t ANS_MEMBER = '{is_member: 1'b1, min_index: '0, min_key: '0,
                                  bad_index: 1'b0};

  // directed row: either a resize or one operation, answer typed or predicted
  typedef struct packed {
    logic                resize;
    logic [SIZE_W-1:0]   size_val;
    logic [MODE_W-1:0]   mode;
    logic [IDX_W-1:0]    slot;
    logic [KEY_IN_W-1:0] key;
    logic                typed;
    res_t                ans;
  } dir_row_t;

  localparam int DIR_N = 28;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // empty table after reset, then extremes of slot and key
    '{1'b0, '0, MODE_FIND,   10'd0,    16'h0000, 1'b1, ANS_EMPTY},
    '{1'b0, '0, MODE_QUERY,  10'd1023, 16'h0000, 1'b1, ANS_NONE},
    '{1'b0, '0, MODE_INSERT, 10'd1023, 16'hFFFF, 1'b1, ANS_NONE},
    '{1'b0, '0, MODE_FIND,   10'd0,    16'h0000, 1'b1, '{1'b0, 11'd1023, 17'h0FFFF, 1'b0}},
    '{1'b0, '0, MODE_INSERT, 10'd0,    16'h0000, 1'b1, ANS_NONE},
    '{1'b0, '0, MODE_QUERY,  10'd1023, 16'h0000, 1'b1, ANS_MEMBER},
    '{1'b0, '0, MODE_FIND,   10'd0,    16'h0000, 1'b1, ANS_NONE},
    // tie between slot 0 and slot 512, lowest index wins
    '{1'b0, '0, MODE_INSERT, 10'd512,  16'h0000, 1'b1, ANS_NONE},
    '{1'b0, '0, MODE_FIND,   10'd0,    16'h0000, 1'b1, ANS_NONE},
    '{1'b0, '0, MODE_REMOVE, 10'd0,    16'hFFFF, 1'b1, ANS_NONE},
    '{1'b0, '0, MODE_FIND,   10'd0,    16'h0000, 1'b1, '{1'b0, 11'd512, 17'h00000, 1'b0}},
    // spare modes leave the table alone
    '{1'b0, '0, MODE_SPARE_FIRST, 10'd1023, 16'hFFFF, 1'b1, ANS_NONE},
    '{1'b0, '0, MODE_SPARE_LAST,  10'd0,    16'h0000, 1'b1, ANS_NONE},
    '{1'b0, '0, MODE_INSERT, 10'd5,    16'h5555, 1'b0, ANS_NONE},
    '{1'b0, '0, MODE_FIND,   10'd0,    16'h0000, 1'b0, ANS_NONE},
    // clear empties every slot
    '{1'b0, '0, MODE_CLEAR,  10'd0,    16'h0000, 1'b1, ANS_NONE},
    '{1'b0, '0, MODE_FIND,   10'd0,    16'h0000, 1'b1, ANS_EMPTY},
    // four slots: indices from 4 up are flagged
    '{1'b1, 11'd4, '0, '0, '0, 1'b0, ANS_NONE},
    '{1'b0, '0, MODE_INSERT, 10'd3,    16'h1234, 1'b1, ANS_NONE},
    '{1'b0, '0, MODE_INSERT, 10'd4,    16'h0001, 1'b1, ANS_BAD},
    '{1'b0, '0, MODE_REMOVE, 10'd1023, 16'h0000, 1'b1, ANS_BAD},
    '{1'b0, '0, MODE_QUERY,  10'd4,    16'h0000, 1'b1, ANS_BAD},
    '{1'b0, '0, MODE_FIND,   10'd0,    16'h0000, 1'b1, '{1'b0, 11'd3, 17'h01234, 1'b0}},
    // size zero acts as one slot
    '{1'b1, 11'd0, '0, '0, '0, 1'b0, ANS_NONE},
    '{1'b0, '0, MODE_INSERT, 10'd1,    16'hFFFF, 1'b1, ANS_BAD},
    '{1'b0, '0, MODE_INSERT, 10'd0,    16'h7FFF, 1'b0, ANS_NONE},
    '{1'b0, '0, MODE_FIND,   10'd0,    16'h0000, 1'b0, ANS_NONE},
    // size above the slot count acts as full
    '{1'b1, 11'h7FF, '0, '0, '0, 1'b0, ANS_NONE}
  };

  // random phases: table size and idle profile
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 160;
  localparam logic [SIZE_W-1:0] PHASE_SIZE [PHASES] = '{
    11'd1024, 11'd7, 11'd1, 11'd3, 11'd1024, 11'd64, 11'd2, 11'd200, 11'h7FF, 11'd5
  };
  localparam int unsigned GAP_PCT [4]   = '{0, 75, 0, 19};
  localparam int unsigned STALL_PCT [4] = '{0, 0, 75, 19};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [MODE_W-1:0]     mode_i;
  logic [IDX_W-1:0]      slot_index_i;
  logic [KEY_IN_W-1:0]   key_in_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  is_member_o;
  logic [SIZE_W-1:0]     min_index_o;
  logic [KEY_W-1:0]      min_key_o;
  logic                  bad_index_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [PDATA_W-1:0]    pwdata;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  // shadow of the table and of the size register
  logic [KEY_W-1:0]      shadow_key [SLOTS];
  logic                  shadow_member [SLOTS];
  logic [SIZE_W-1:0]     shadow_size;

  res_t                  answer_q [$];
  int unsigned           send_gap_pct = 0;
  int unsigned           recv_stall_pct = 0;
  int unsigned           hold_left = 0;
  int unsigned           faults = 0;

  keyed_slot_table_with_argmin dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .slot_index_i (slot_index_i),
    .key_in_i     (key_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .is_member_o  (is_member_o),
    .min_index_o  (min_index_o),
    .min_key_o    (min_key_o),
    .bad_index_o  (bad_index_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // number of slots in use, size clamped to 1..SLOTS
  function automatic int unsigned live_slots();
    if (shadow_size == '0) begin
      return 1;
    end
    if (shadow_size > SLOTS) begin
      return SLOTS;
    end
    return shadow_size;
  endfunction

  function automatic void clear_shadow();
    foreach (shadow_key[i]) begin
      shadow_key[i] = KEY_EMPTY;
      shadow_member[i] = 1'b0;
    end
  endfunction

  // apply one operation to the shadow table and work out its answer
  task automatic run_slot_op(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] slot,
                             input logic [KEY_IN_W-1:0] key, output res_t ans);
    int unsigned n;
    int unsigned best_at;
    logic [KEY_W-1:0] best;
    n = live_slots();
    ans = '0;
    case (mode)
      MODE_INSERT, MODE_REMOVE, MODE_QUERY: begin
        if (slot >= n) begin
          ans.bad_index = 1'b1;
        end else if (mode == MODE_INSERT) begin
          shadow_member[slot] = 1'b1;
          shadow_key[slot] = {1'b0, key};
        end else if (mode == MODE_REMOVE) begin
          shadow_member[slot] = 1'b0;
          shadow_key[slot] = KEY_EMPTY;
        end else begin
          ans.is_member = shadow_member[slot];
        end
      end
      MODE_CLEAR: begin
        clear_shadow();
      end
      MODE_FIND: begin
        // strict compare keeps the lowest index on ties
        best = shadow_key[0];
        best_at = 0;
        for (int i = 1; i < n; i++) begin
          if (shadow_key[i] < best) begin
            best = shadow_key[i];
            best_at = i;
          end
        end
        ans.min_index = SIZE_W'(best_at);
        ans.min_key = best;
      end
      default: begin
      end
    endcase
  endtask

  // offer one operation, hold it until the transfer, then record its answer
  task automatic offer_op(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] slot,
                          input logic [KEY_IN_W-1:0] key, input logic typed,
                          input res_t typed_ans);
    res_t ans;
    @(negedge clk_i);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    slot_index_i <= slot;
    key_in_i     <= key;
    do @(posedge clk_i); while (in_stall_o);
    run_slot_op(mode, slot, key, ans);
    answer_q.push_back(typed ? typed_ans : ans);
  endtask

  // stop offering and wait until every answer has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // register write, junk in the unused upper bits; empties the table
  task automatic write_table_size(input logic [SIZE_W-1:0] new_size);
    logic [PDATA_W-1:0] wdata;
    wdata = $urandom;
    wdata[SIZE_W-1:0] = new_size;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TABLE_SIZE, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_size = new_size;
    clear_shadow();
  endtask

  // one random phase at a given table size and idle profile
  task automatic random_phase(input logic [SIZE_W-1:0] new_size, input int unsigned gap_pct,
                              input int unsigned stall_pct);
    int unsigned n;
    int unsigned pick;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0] slot;
    logic [KEY_IN_W-1:0] key;
    drain();
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    write_table_size(new_size);
    n = live_slots();
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      // long receiver hold while the sender keeps pushing
      if (k == 40 && gap_pct == 0) begin
        hold_left = 60;
      end
      // sender pause until the table has answered everything
      if (k == 100) begin
        drain();
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
        mode = MODE_INSERT;
      end else if (pick < 50) begin
        mode = MODE_REMOVE;
      end else if (pick < 68) begin
        mode = MODE_QUERY;
      end else if (pick < 70) begin
        mode = MODE_CLEAR;
      end else if (pick < 95) begin
        mode = MODE_FIND;
      end else begin
        mode = MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
      end
      // mostly slots in use, now and then any index
      if ($urandom_range(99) < 88) begin
        slot = IDX_W'($urandom_range(n - 1));
      end else begin
        slot = IDX_W'($urandom);
      end
      // keys lean toward zero, the top and a few small values for ties
      pick = $urandom_range(99);
      if (pick < 15) begin
        key = '0;
      end else if (pick < 25) begin
        key = '1;
      end else if (pick < 45) begin
        key = KEY_IN_W'($urandom_range(15));
      end else begin
        key = KEY_IN_W'($urandom);
      end
      offer_op(mode, slot, key, 1'b0, ANS_NONE);
    end
  endtask

  // receiver: random stalls, or a fixed hold when asked for
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // result check against the oldest pending answer
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answer_q.size() == 0) begin
        $error("result transfer with no operation pending");
        faults++;
      end else begin
        want = answer_q.pop_front();
        if (is_member_o !== want.is_member) begin
          $error("is_member: expected %0d, actual %0d", want.is_member, is_member_o);
          faults++;
        end
        if (min_index_o !== want.min_index) begin
          $error("min_index: expected %0d, actual %0d", want.min_index, min_index_o);
          faults++;
        end
        if (min_key_o !== want.min_key) begin
          $error("min_key: expected %0d, actual %0d", want.min_key, min_key_o);
          faults++;
        end
        if (bad_index_o !== want.bad_index) begin
          $error("bad_index: expected %0d, actual %0d", want.bad_index, bad_index_o);
          faults++;
        end
      end
    end
  end

  // reset, directed table, random phases, verdict
  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = MODE_INSERT;
    slot_index_i = '0;
    key_in_i     = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    shadow_size  = SIZE_RESET;
    clear_shadow();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].resize) begin
        drain();
        write_table_size(DIR_ROWS[r].size_val);
      end else begin
        offer_op(DIR_ROWS[r].mode, DIR_ROWS[r].slot, DIR_ROWS[r].key, DIR_ROWS[r].typed,
                 DIR_ROWS[r].ans);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      random_phase(PHASE_SIZE[p], GAP_PCT[p % 4], STALL_PCT[p % 4]);
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
